@@ rtl/upca_pkg.sv @@
// Shared constants, types and register codes for the ungapped profile cell array.
// No dependencies; every other file in rtl/ imports this package.
package upca_pkg;

   localparam int NUM_CELLS        = 256;
   localparam int GROUP_SIZE       = 16;
   localparam int SYMBOLS_PER_WORD = 16;
   localparam int QUEUE_DEPTH      = 4096;

   localparam int SCORE_W     = 8;
   localparam int SYM_W       = 2;
   localparam int WORD_IDX_W  = 4;
   localparam int WORD_DATA_W = 32;
   localparam int PROF_W      = 12;
   localparam int PLEN_W      = 13;
   localparam int SEG_W       = 16;
   localparam int MASK_W      = 16;
   localparam int HITS_W      = 24;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_WORDS   = 1 << WORD_IDX_W;
   localparam int MAX_PROFILE = 4096;

   localparam int Q_ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef enum logic [0:0] {
      CSR_PROFILE_LENGTH = 1'b0,
      CSR_SEGMENT_COUNT  = 1'b1
   } csr_index_type;

   typedef logic [3:0][SCORE_W-1:0] score_set_type;

   typedef struct packed {
      logic step;
      logic first_pos;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic [PROF_W-1:0] profile_index;
      logic [SEG_W-1:0]  segment_index;
      logic              is_final;
      logic              run_start;
   } step_meta_type;

endpackage

@@ rtl/upca_chan_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on upca_pkg.
interface upca_req_if;
   import upca_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [WORD_IDX_W-1:0]         word_index;
   logic [WORD_DATA_W-1:0]        word_data;
   logic signed [SCORE_W-1:0]     score_0;
   logic signed [SCORE_W-1:0]     score_1;
   logic signed [SCORE_W-1:0]     score_2;
   logic signed [SCORE_W-1:0]     score_3;

   modport source (output valid, req_type, word_index, word_data,
                   score_0, score_1, score_2, score_3, input ready);
   modport sink   (input valid, req_type, word_index, word_data,
                   score_0, score_1, score_2, score_3, output ready);
endinterface

interface upca_rsp_if;
   import upca_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PROF_W-1:0]     profile_index;
   logic [SEG_W-1:0]      segment_index;
   logic [MASK_W-1:0]     group_mask;
   logic                  is_final;
   logic [HITS_W-1:0]     hit_count;

   modport source (output valid, profile_index, segment_index, group_mask,
                   is_final, hit_count, input ready);
   modport sink   (input valid, profile_index, segment_index, group_mask,
                   is_final, hit_count, output ready);
endinterface

@@ rtl/ungapped_profile_cell_array.sv @@
// Top level: row of scoring cells, carry queue, step sequencing and config registers.
// Depends on upca_pkg, upca_chan_if, upca_cell, upca_carry_queue, upca_report.
//
// Accepts one word per clock: a load word writes sixteen symbols, a step word
// updates all 256 cells in parallel in the cycle it is accepted. A step's report
// passes through the s1 merge register and then the response register before it
// is valid on the response channel; steps with no hit that are not the last
// profile position produce no response. The sustained rate is one word per cycle,
// set by the cell update and the one-read-one-write carry queue memory (4096 x 8);
// it only drops when a pending response is held by rsp_chan.ready. The queue
// needs no clearing pass after reset. Configuration writes take effect at once.
module ungapped_profile_cell_array (
   input  logic                            clock,
   input  logic                            reset,
   upca_req_if.sink                        req_chan,
   upca_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  upca_pkg::csr_index_type         csr_index,
   input  logic [upca_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import upca_pkg::*;

   logic [PLEN_W-1:0]  profile_length_ff;
   logic [SEG_W-1:0]   segment_count_ff;
   logic [PROF_W-1:0]  step_index_ff;
   logic [SEG_W-1:0]   segment_counter_ff;
   logic [SCORE_W-1:0] left_score_ff, left_score_in;

   logic [PLEN_W-1:0]  plen;
   logic [SEG_W-1:0]   scount;
   logic               first_pos, last_pos, first_seg, last_seg;
   logic               step_fire, load_fire, report_free;

   cell_ctrl_type      cell_ctrl;
   queue_ctrl_type     queue_ctrl;
   step_meta_type      meta;
   score_set_type      scores;
   logic [SCORE_W-1:0] pop_data;
   logic [SCORE_W-1:0] cell_score [NUM_CELLS];
   logic [NUM_CELLS-1:0] hits;

   assign req_chan.ready = report_free;
   assign step_fire = req_chan.valid && report_free && (req_chan.req_type == REQ_STEP);
   assign load_fire = req_chan.valid && report_free && (req_chan.req_type == REQ_LOAD);

   always_comb begin
      if (profile_length_ff == '0) begin
         plen = PLEN_W'(1);
      end else if (profile_length_ff > PLEN_W'(MAX_PROFILE)) begin
         plen = PLEN_W'(MAX_PROFILE);
      end else begin
         plen = profile_length_ff;
      end
      scount    = (segment_count_ff == '0) ? SEG_W'(1) : segment_count_ff;
      first_pos = (step_index_ff == '0);
      last_pos  = ({1'b0, step_index_ff} >= plen - 1'b1);
      first_seg = (segment_counter_ff == '0);
      last_seg  = (segment_counter_ff >= scount - 1'b1);

      scores = {req_chan.score_3, req_chan.score_2, req_chan.score_1, req_chan.score_0};

      cell_ctrl.step      = step_fire;
      cell_ctrl.first_pos = first_pos;

      queue_ctrl.clear = step_fire && first_pos && first_seg;
      queue_ctrl.push  = step_fire && !last_seg && !first_pos;
      queue_ctrl.pop   = step_fire && !first_seg && !last_pos;

      left_score_in = queue_ctrl.pop ? pop_data : '0;

      meta.profile_index = step_index_ff;
      meta.segment_index = segment_counter_ff;
      meta.is_final      = last_pos;
      meta.run_start     = first_pos && first_seg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_length_ff <= PLEN_W'(1);
         segment_count_ff  <= SEG_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PROFILE_LENGTH: profile_length_ff <= csr_write_data[PLEN_W-1:0];
            CSR_SEGMENT_COUNT:  segment_count_ff  <= csr_write_data[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff      <= '0;
         segment_counter_ff <= '0;
         left_score_ff      <= '0;
      end else if (step_fire) begin
         left_score_ff <= left_score_in;
         if (last_pos) begin
            step_index_ff      <= '0;
            segment_counter_ff <= last_seg ? '0 : segment_counter_ff + 1'b1;
         end else begin
            step_index_ff <= step_index_ff + 1'b1;
         end
      end
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam int WORD = i / SYMBOLS_PER_WORD;
      localparam int SLOT = i % SYMBOLS_PER_WORD;

      logic               sym_we;
      logic [SYM_W-1:0]   sym_data;
      logic [SCORE_W-1:0] prev_score;

      if (WORD < NUM_WORDS) begin : g_we
         assign sym_we = load_fire && (req_chan.word_index == WORD_IDX_W'(WORD));
      end else begin : g_no_we
         assign sym_we = 1'b0;
      end

      if (SYM_W * SLOT + SYM_W <= WORD_DATA_W) begin : g_sym
         assign sym_data = req_chan.word_data[SYM_W*SLOT +: SYM_W];
      end else begin : g_sym_zero
         assign sym_data = '0;
      end

      if (i == 0) begin : g_left
         assign prev_score = left_score_ff;
      end else begin : g_chain
         assign prev_score = cell_score[i-1];
      end

      upca_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .prev_score (prev_score),
         .scores     (scores),
         .sym_we     (sym_we),
         .sym_data   (sym_data),
         .score_out  (cell_score[i]),
         .hit        (hits[i])
      );
   end

   upca_carry_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (queue_ctrl),
      .push_data (cell_score[NUM_CELLS-1]),
      .pop_data  (pop_data)
   );

   upca_report u_report (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .hits       (hits),
      .meta       (meta),
      .free       (report_free),
      .rsp_chan   (rsp_chan)
   );

   a_rsp_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.group_mask != '0 || rsp_chan.is_final))
      else $error("response word without hit or final flag");

   a_first_seg_left_zero: assert property (@(posedge clock) disable iff (reset)
      (step_fire && first_seg) |=> (left_score_ff == '0))
      else $error("left score not zero in first segment");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !last_pos) |=> (step_index_ff == $past(step_index_ff) + 1'b1))
      else $error("profile position did not advance");

endmodule

@@ rtl/upca_cell.sv @@
// One scoring cell: stored symbol, 8-bit score, hit/underflow reset.
// Depends on upca_pkg.
module upca_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  upca_pkg::cell_ctrl_type      ctrl,
   input  logic [upca_pkg::SCORE_W-1:0] prev_score,
   input  upca_pkg::score_set_type      scores,
   input  logic                         sym_we,
   input  logic [upca_pkg::SYM_W-1:0]   sym_data,
   output logic [upca_pkg::SCORE_W-1:0] score_out,
   output logic                         hit
);
   import upca_pkg::*;

   logic [SYM_W-1:0]   sym_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] score_in;
   logic [SCORE_W-1:0] prev;
   logic [SCORE_W-1:0] match;
   logic [SCORE_W:0]   sum;
   logic               carry;
   logic               neg;

   always_comb begin
      prev     = ctrl.first_pos ? '0 : prev_score;
      match    = scores[sym_ff];
      sum      = {1'b0, prev} + {1'b0, match};
      carry    = sum[SCORE_W];
      neg      = match[SCORE_W-1];
      score_in = (carry != neg) ? '0 : sum[SCORE_W-1:0];
      hit      = carry && !neg;
   end

   // symbols have no reset: a cell scores whatever symbol it holds, loaded or not
   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_ff <= sym_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else if (ctrl.step) begin
         score_ff <= score_in;
      end
   end

   assign score_out = score_ff;

endmodule

@@ rtl/upca_carry_queue.sv @@
// FIFO carrying the last cell's score into cell 0 of the next segment.
// Depends on upca_pkg; memory with registered read and write-through bypass.
module upca_carry_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  upca_pkg::queue_ctrl_type     ctrl,
   input  logic [upca_pkg::SCORE_W-1:0] push_data,
   output logic [upca_pkg::SCORE_W-1:0] pop_data
);
   import upca_pkg::*;

   logic [SCORE_W-1:0]  mem [QUEUE_DEPTH];
   logic [SCORE_W-1:0]  rd_data_ff;
   logic [Q_ADDR_W-1:0] head_ff, head_in;
   logic [Q_ADDR_W-1:0] tail_ff, tail_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic [Q_ADDR_W-1:0] head_base, tail_base;
   logic [Q_CNT_W-1:0]  count_base, count_pushed;
   logic                push_ok, pop_ok;

   function automatic logic [Q_ADDR_W-1:0] wrap_inc(input logic [Q_ADDR_W-1:0] p);
      wrap_inc = (p == Q_ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_base    = ctrl.clear ? '0 : head_ff;
      tail_base    = ctrl.clear ? '0 : tail_ff;
      count_base   = ctrl.clear ? '0 : count_ff;
      push_ok      = ctrl.push && (count_base != Q_CNT_W'(QUEUE_DEPTH));
      count_pushed = count_base + Q_CNT_W'(push_ok);
      pop_ok       = ctrl.pop && (count_pushed != '0);
      count_in     = count_pushed - Q_CNT_W'(pop_ok);
      tail_in      = push_ok ? wrap_inc(tail_base) : tail_base;
      head_in      = pop_ok ? wrap_inc(head_base) : head_base;
      if (!pop_ok) begin
         pop_data = '0;
      end else if (count_base == '0) begin
         pop_data = push_data;
      end else begin
         pop_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[tail_base] <= push_data;
      end
      rd_data_ff <= (push_ok && tail_base == head_in) ? push_data : mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/upca_report.sv @@
// Merge stage: folds cell hits into group masks, counts steps with a hit, drives responses.
// Depends on upca_pkg and upca_rsp_if.
module upca_report (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_valid,
   input  logic [upca_pkg::NUM_CELLS-1:0] hits,
   input  upca_pkg::step_meta_type        meta,
   output logic                           free,
   upca_rsp_if.source                     rsp_chan
);
   import upca_pkg::*;

   logic [MASK_W-1:0] mask_in;
   logic              s1_valid_ff;
   logic [MASK_W-1:0] s1_mask_ff;
   step_meta_type     s1_meta_ff;
   logic [HITS_W-1:0] hits_ff, hits_in;
   logic              emit, s1_move;

   logic              rsp_valid_ff;
   logic [PROF_W-1:0] rsp_prof_ff;
   logic [SEG_W-1:0]  rsp_seg_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_final_ff;
   logic [HITS_W-1:0] rsp_hits_ff;

   always_comb begin
      mask_in = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (i / GROUP_SIZE < MASK_W) begin
            mask_in[$clog2(MASK_W)'(i / GROUP_SIZE)] |= hits[i];
         end
      end
   end

   always_comb begin
      emit    = (s1_mask_ff != '0) || s1_meta_ff.is_final;
      s1_move = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_chan.ready);
      free    = !s1_valid_ff || s1_move;
      hits_in = s1_meta_ff.run_start ? '0 : hits_ff;
      if (s1_mask_ff != '0 && hits_in != {HITS_W{1'b1}}) begin
         hits_in = hits_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step_valid) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            hits_ff <= hits_in;
         end
         if (s1_move && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         s1_mask_ff <= mask_in;
         s1_meta_ff <= meta;
      end
      if (s1_move && emit) begin
         rsp_prof_ff  <= s1_meta_ff.profile_index;
         rsp_seg_ff   <= s1_meta_ff.segment_index;
         rsp_mask_ff  <= s1_mask_ff;
         rsp_final_ff <= s1_meta_ff.is_final;
         rsp_hits_ff  <= hits_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.profile_index = rsp_prof_ff;
   assign rsp_chan.segment_index = rsp_seg_ff;
   assign rsp_chan.group_mask    = rsp_mask_ff;
   assign rsp_chan.is_final      = rsp_final_ff;
   assign rsp_chan.hit_count     = rsp_hits_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for ungapped_profile_cell_array: directed table, then random phases.
// Carries its own cell-row score predictor; checks responses against it or a fixed report.
// Depends on rtl/upca_pkg.sv, rtl/upca_chan_if.sv and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import upca_pkg::*;

   localparam int STALL_LIMIT    = 2000;
   localparam int PRESSURE_HOLD  = 400;
   localparam int DRAIN_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 28;
   localparam int PRESSURE_PHASE = 5;

   typedef struct packed {
      logic                      req_type;
      logic [WORD_IDX_W-1:0]     word_index;
      logic [WORD_DATA_W-1:0]    word_data;
      logic [3:0][SCORE_W-1:0]   scores;
   } req_word_type;

   typedef struct packed {
      logic [PROF_W-1:0] profile_index;
      logic [SEG_W-1:0]  segment_index;
      logic [MASK_W-1:0] group_mask;
      logic              is_final;
      logic [HITS_W-1:0] hit_count;
   } report_type;

   typedef struct packed {
      logic                  is_reg;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      req_word_type          word;
      logic                  typed;
      report_type            expected;
   } plan_row_type;

   // single-position run: no carry possible, report is the final one with counters cleared
   localparam report_type LONE_FINAL = '{profile_index: '0, segment_index: '0, group_mask: '0,
                                         is_final: 1'b1, hit_count: '0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   upca_req_if req_chan ();
   upca_rsp_if rsp_chan ();

   ungapped_profile_cell_array u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // predictor state
   logic [SYM_W-1:0]   symbol_mem [NUM_CELLS];
   logic [SCORE_W-1:0] cell_mem   [NUM_CELLS] = '{default: '0};
   logic [SCORE_W-1:0] carry_fifo [$];
   logic [SCORE_W-1:0] tail_score = '0;
   logic [SCORE_W-1:0] left_in    = '0;
   int unsigned        step_pos   = 0;
   int unsigned        seg_pos    = 0;
   logic [HITS_W-1:0]  run_hits   = '0;
   logic [PLEN_W-1:0]  plen_reg   = PLEN_W'(1);
   logic [SEG_W-1:0]   scount_reg = SEG_W'(1);

   report_type   pending_reports [$];
   plan_row_type plan [$];
   int           mismatch_count = 0;
   bit           no_idle = 1'b0;
   int           rsp_hold_left = 0;

   function automatic void apply_word(input req_word_type w, output bit has_report,
                                      output report_type rep);
      int unsigned        plen;
      int unsigned        scount;
      int                 base;
      bit                 first_pos, last_pos, first_seg, last_seg;
      logic [SCORE_W-1:0] prior [NUM_CELLS];
      logic [SCORE_W-1:0] prev;
      logic [SCORE_W-1:0] match;
      logic [SCORE_W:0]   sum;
      logic [MASK_W-1:0]  mask;
      has_report = 1'b0;
      rep = '0;
      if (w.req_type == REQ_LOAD) begin
         base = w.word_index * SYMBOLS_PER_WORD;
         for (int k = 0; k < SYMBOLS_PER_WORD; k++)
            if (base + k < NUM_CELLS)
               symbol_mem[base + k] = w.word_data[2*k +: 2];
         return;
      end
      plen = (plen_reg == 0) ? 1 : ((plen_reg > MAX_PROFILE) ? MAX_PROFILE : plen_reg);
      scount = (scount_reg == 0) ? 1 : scount_reg;
      first_pos = (step_pos == 0);
      last_pos  = (step_pos >= plen - 1);
      first_seg = (seg_pos == 0);
      last_seg  = (seg_pos >= scount - 1);
      if (first_pos && first_seg) begin
         carry_fifo.delete();
         run_hits = '0;
      end
      if (!last_seg && !first_pos && carry_fifo.size() < QUEUE_DEPTH)
         carry_fifo.push_back(tail_score);
      prior = cell_mem;
      mask = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (first_pos)
            prev = '0;
         else if (i == 0)
            prev = left_in;
         else
            prev = prior[i-1];
         match = w.scores[symbol_mem[i]];
         sum = {1'b0, prev} + {1'b0, match};
         cell_mem[i] = (sum[SCORE_W] != match[SCORE_W-1]) ? '0 : sum[SCORE_W-1:0];
         if (sum[SCORE_W] && !match[SCORE_W-1] && i / GROUP_SIZE < MASK_W)
            mask[i / GROUP_SIZE] = 1'b1;
      end
      tail_score = cell_mem[NUM_CELLS-1];
      if (first_seg || last_pos || carry_fifo.size() == 0)
         left_in = '0;
      else
         left_in = carry_fifo.pop_front();
      if (mask != 0 && run_hits != '1)
         run_hits++;
      if (mask != 0 || last_pos) begin
         has_report = 1'b1;
         rep.profile_index = step_pos[PROF_W-1:0];
         rep.segment_index = seg_pos[SEG_W-1:0];
         rep.group_mask    = mask;
         rep.is_final      = last_pos;
         rep.hit_count     = run_hits;
      end
      if (last_pos) begin
         step_pos = 0;
         seg_pos = last_seg ? 0 : ((seg_pos + 1) & 32'hFFFF);
      end else begin
         step_pos = (step_pos + 1) & 32'hFFF;
      end
   endfunction

   task automatic send_word(input req_word_type w, input bit typed,
                            input report_type typed_report);
      bit         has_report;
      report_type rep;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= w.req_type;
      req_chan.word_index <= w.word_index;
      req_chan.word_data  <= w.word_data;
      req_chan.score_0    <= w.scores[0];
      req_chan.score_1    <= w.scores[1];
      req_chan.score_2    <= w.scores[2];
      req_chan.score_3    <= w.scores[3];
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_word(w, has_report, rep);
      if (typed)
         pending_reports.push_back(typed_report);
      else if (has_report)
         pending_reports.push_back(rep);
   endtask

   // registers change only with no word in flight
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_PROFILE_LENGTH)
         plen_reg = data[PLEN_W-1:0];
      else
         scount_reg = data;
   endtask

   function automatic void plan_step(input logic [7:0] s0, s1, s2, s3, input logic typed);
      plan_row_type row;
      row = '0;
      row.word.req_type = REQ_STEP;
      row.word.scores   = {s3, s2, s1, s0};
      row.typed         = typed;
      row.expected      = LONE_FINAL;
      plan.push_back(row);
   endfunction

   function automatic void plan_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.is_reg    = 1'b1;
      row.reg_index = idx;
      row.reg_data  = data;
      plan.push_back(row);
   endfunction

   function automatic void field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = '{rsp_chan.profile_index, rsp_chan.segment_index, rsp_chan.group_mask,
                 rsp_chan.is_final, rsp_chan.hit_count};
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report expected none actual %p", $time, got);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.profile_index !== want.profile_index)
               field_mismatch("profile_index", 32'(want.profile_index),
                              32'(got.profile_index));
            if (got.segment_index !== want.segment_index)
               field_mismatch("segment_index", 32'(want.segment_index),
                              32'(got.segment_index));
            if (got.group_mask !== want.group_mask)
               field_mismatch("group_mask", 32'(want.group_mask), 32'(got.group_mask));
            if (got.is_final !== want.is_final)
               field_mismatch("is_final", 32'(want.is_final), 32'(got.is_final));
            if (got.hit_count !== want.hit_count)
               field_mismatch("hit_count", 32'(want.hit_count), 32'(got.hit_count));
         end
      end
   end

   initial begin : response_sink
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= 17);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      plan_row_type          row;
      req_word_type          w;
      logic [CSR_DATA_W-1:0] reg_value;
      int                    mode;
      int                    count;
      bit                    pressure;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_LOAD;
      req_chan.word_index = '0;
      req_chan.word_data  = '0;
      req_chan.score_0    = '0;
      req_chan.score_1    = '0;
      req_chan.score_2    = '0;
      req_chan.score_3    = '0;
      csr_write_en        = 1'b0;
      csr_index           = CSR_PROFILE_LENGTH;
      csr_write_data      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every symbol word is loaded before the first step
      for (int i = 0; i < NUM_WORDS; i++) begin
         row = '0;
         row.word.req_type   = REQ_LOAD;
         row.word.word_index = WORD_IDX_W'(i);
         case (i)
            0:       row.word.word_data = 32'h0000_0000;
            1:       row.word.word_data = 32'hFFFF_FFFF;
            2:       row.word.word_data = 32'h5555_5555;
            3:       row.word.word_data = 32'hAAAA_AAAA;
            default: row.word.word_data = $urandom();
         endcase
         plan.push_back(row);
      end
      plan_step(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1);
      plan_step(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);
      plan_reg(CSR_PROFILE_LENGTH, 16'd3);
      plan_reg(CSR_SEGMENT_COUNT, 16'd2);
      plan_step(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0);
      plan_step(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0);
      plan_step(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0);
      plan_step(8'h80, 8'h7F, 8'h00, 8'hFF, 1'b0);
      plan_step(8'h64, 8'h9C, 8'h32, 8'hCE, 1'b0);
      plan_step(8'h7F, 8'h01, 8'h80, 8'h00, 1'b0);
      // zero registers act as one; the run has wrapped back to segment 0
      plan_reg(CSR_PROFILE_LENGTH, 16'd0);
      plan_reg(CSR_SEGMENT_COUNT, 16'd0);
      plan_step(8'h7F, 8'hFF, 8'h00, 8'h01, 1'b1);

      foreach (plan[r]) begin
         if (plan[r].is_reg)
            write_reg(plan[r].reg_index, plan[r].reg_data);
         else
            send_word(plan[r].word, plan[r].typed, plan[r].expected);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pressure = (phase == PRESSURE_PHASE);
         no_idle  = (phase >= 12 && phase < 17);
         if (pressure) begin
            write_reg(CSR_PROFILE_LENGTH, 16'd1);
            write_reg(CSR_SEGMENT_COUNT, 16'd1);
            rsp_hold_left = PRESSURE_HOLD;
            count = 120;
            mode = 1;
         end else begin
            if ($urandom_range(9) < 7) begin
               case ($urandom_range(9))
                  0:       reg_value = 16'd0;
                  1:       reg_value = 16'hFFFF;
                  2:       reg_value = CSR_DATA_W'($urandom_range(4097, 200));
                  default: reg_value = CSR_DATA_W'($urandom_range(12, 1));
               endcase
               write_reg(CSR_PROFILE_LENGTH, reg_value);
            end
            if ($urandom_range(9) < 7) begin
               case ($urandom_range(9))
                  0:       reg_value = 16'd0;
                  1:       reg_value = 16'hFFFF;
                  default: reg_value = CSR_DATA_W'($urandom_range(6, 1));
               endcase
               write_reg(CSR_SEGMENT_COUNT, reg_value);
            end
            count = $urandom_range(60, 30);
            mode = $urandom_range(2);
         end
         for (int n = 0; n < count; n++) begin
            w.req_type   = (pressure || $urandom_range(99) >= 8) ? REQ_STEP : REQ_LOAD;
            w.word_index = WORD_IDX_W'($urandom_range(NUM_WORDS - 1));
            w.word_data  = $urandom();
            for (int k = 0; k < 4; k++) begin
               case (mode)
                  0: w.scores[k] = SCORE_W'($urandom_range(255));
                  1: w.scores[k] = ($urandom_range(9) < 8)
                                   ? SCORE_W'($urandom_range(127, 32))
                                   : SCORE_W'($urandom_range(255));
                  default: begin
                     case ($urandom_range(3))
                        0:       w.scores[k] = 8'h7F;
                        1:       w.scores[k] = 8'h80;
                        2:       w.scores[k] = 8'h00;
                        default: w.scores[k] = 8'hFF;
                     endcase
                  end
               endcase
            end
            send_word(w, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
